/* rtl/rcflk_pkg.sv */
// ----------------------------------------------------------------------------
// rcflk_pkg
// Shared types and constants for the radio frame link keeper.
// ----------------------------------------------------------------------------
package rcflk_pkg;

    localparam int FRAME_BYTES = 16;
    localparam int ADDR_W      = 40;
    localparam int POS_W       = $clog2(FRAME_BYTES + 1);
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int TICK_W      = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int NUM_STICK   = 5;                 // roll, pitch, yaw, throttle, buttons
    localparam int STEP_W      = $clog2(NUM_STICK + 1);

    localparam logic [7:0] HDR_BYTE0    = 8'h01;
    localparam logic [7:0] HDR_BYTE1    = 8'h03;
    localparam logic [7:0] ACK_BYTE1    = 8'h83;
    localparam logic [7:0] ACK_BYTE3    = 8'd11;
    localparam logic [IDX_W-1:0] BUTTON_POS = IDX_W'(8);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(FRAME_BYTES - 1);

    localparam logic [ADDR_W-1:0] ACK_ADDR_RST     = '0;
    localparam logic [ADDR_W-1:0] DEFAULT_ADDR_RST = '0;
    localparam logic [TICK_W-1:0] TIMEOUT_RST      = 16'd2000;
    localparam logic [3:0]        THROTTLE_POS_RST = 4'd4;
    localparam logic [3:0]        YAW_POS_RST      = 4'd5;
    localparam logic [3:0]        PITCH_POS_RST    = 4'd6;
    localparam logic [3:0]        ROLL_POS_RST     = 4'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACK_ADDR     = 3'd0,
        CFG_DEFAULT_ADDR = 3'd1,
        CFG_TIMEOUT      = 3'd2,
        CFG_THROTTLE_POS = 3'd3,
        CFG_YAW_POS      = 3'd4,
        CFG_PITCH_POS    = 3'd5,
        CFG_ROLL_POS     = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        KIND_UPDATE = 2'd0,
        KIND_ACK    = 2'd1,
        KIND_LOST   = 2'd2
    } kind_t;

    typedef enum logic {
        OP_BYTE = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] data_byte;
        logic       frame_start;
    } rcflk_in_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        roll;
        logic [7:0]        pitch;
        logic [7:0]        yaw;
        logic [7:0]        throttle;
        logic [7:0]        buttons;
        logic [7:0]        ack_byte;
        logic              last;
        logic [ADDR_W-1:0] radio_address;
        logic              connected;
    } rcflk_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STICK,
        ST_UPDATE,
        ST_ACK_RD,
        ST_ACK_LD
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic              accept;      // input transaction this cycle
        logic              rd_en;
        logic              rd_stick;    // idx picks a stick position, else a frame address
        logic [IDX_W-1:0]  idx;
        logic              cap_en;
        logic [STEP_W-1:0] cap_idx;
        logic              load_update;
        logic              load_ack;
        logic              ack_last;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic frame_ok;
        logic link_lost;
    } dp_stat_t;

endpackage

/* rtl/rcflk_ctrl.sv */
// ----------------------------------------------------------------------------
// rcflk_ctrl
// Sequencer: input handshake, stick reads, update and ack emission, output
// valid.
// ----------------------------------------------------------------------------
module rcflk_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  rcflk_pkg::dp_stat_t stat,
    output rcflk_pkg::dp_cmd_t  cmd
);
    import rcflk_pkg::*;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [IDX_W-1:0]  ack_idx_reg, ack_idx_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_free;
    logic              load_any;

    assign out_free = !out_valid_reg || m_ready;
    assign m_valid  = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            ack_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            ack_idx_reg   <= ack_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        ack_idx_next = ack_idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && out_free && stat.frame_ok) begin
                    state_next = ST_STICK;
                    step_next  = '0;
                end
            end
            ST_STICK: begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(NUM_STICK)) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    state_next   = ST_ACK_RD;
                    ack_idx_next = '0;
                end
            end
            ST_ACK_RD: begin
                state_next = ST_ACK_LD;
            end
            ST_ACK_LD: begin
                if (out_free) begin
                    ack_idx_next = ack_idx_reg + IDX_W'(1);
                    state_next   = (ack_idx_reg == LAST_IDX) ? ST_IDLE : ST_ACK_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready     = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = out_free;
                cmd.accept = s_valid && out_free;
            end
            ST_STICK: begin
                cmd.rd_en    = (step_reg != STEP_W'(NUM_STICK));
                cmd.rd_stick = 1'b1;
                cmd.idx      = IDX_W'(step_reg);
                cmd.cap_en   = (step_reg != '0);
                cmd.cap_idx  = step_reg - STEP_W'(1);
            end
            ST_UPDATE: begin
                cmd.load_update = out_free;
            end
            ST_ACK_RD: begin
                cmd.rd_en = 1'b1;
                cmd.idx   = ack_idx_reg;
            end
            ST_ACK_LD: begin
                cmd.idx      = ack_idx_reg;
                cmd.load_ack = out_free;
                cmd.ack_last = (ack_idx_reg == LAST_IDX);
            end
            default: ;
        endcase
    end

    // link-lost results load at the tick's own transaction edge
    assign load_any = cmd.load_update || cmd.load_ack || (cmd.accept && stat.link_lost);

    always_comb begin
        if (load_any) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

/* rtl/rcflk_dp.sv */
// ----------------------------------------------------------------------------
// rcflk_dp
// Datapath: configuration registers, frame store, checksum and link timer,
// result register.
// ----------------------------------------------------------------------------
module rcflk_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_valid,
    input  logic [rcflk_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rcflk_pkg::ADDR_W-1:0]          cfg_data,
    input  rcflk_pkg::rcflk_in_t                  s_data,
    input  rcflk_pkg::dp_cmd_t                    cmd,
    output rcflk_pkg::dp_stat_t                   stat,
    output rcflk_pkg::rcflk_out_t                 m_data
);
    import rcflk_pkg::*;

    logic [ADDR_W-1:0] ack_addr_reg;
    logic [ADDR_W-1:0] default_addr_reg;
    logic [TICK_W-1:0] timeout_reg;
    logic [3:0]        throttle_pos_reg, yaw_pos_reg, pitch_pos_reg, roll_pos_reg;

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [7:0]        sum_reg, sum_next;
    logic              link_reg, link_next;
    logic [TICK_W-1:0] idle_reg, idle_next;
    logic [ADDR_W-1:0] cur_addr_reg, cur_addr_next;
    logic              ok0_reg, ok1_reg;

    logic [7:0]        frame_mem [FRAME_BYTES];
    logic [7:0]        rd_data_reg;
    logic [IDX_W-1:0]  rd_addr;
    logic [7:0]        stick_reg [NUM_STICK];
    logic [7:0]        ack_sum_reg;
    rcflk_out_t        out_reg, out_next;

    logic [POS_W-1:0]  pos_eff;
    logic [7:0]        sum_eff;
    logic              is_byte, is_tick, byte_wr;
    logic [TICK_W-1:0] idle_inc;
    logic [7:0]        ack_val;
    logic [ADDR_W-1:0] addr_shift;
    logic [2:0]        addr_byte;

    assign is_byte = cmd.accept && (s_data.op == OP_BYTE);
    assign is_tick = cmd.accept && (s_data.op == OP_TICK);
    assign pos_eff = s_data.frame_start ? '0 : pos_reg;
    assign sum_eff = s_data.frame_start ? '0 : sum_reg;
    assign byte_wr = is_byte && (pos_eff < POS_W'(FRAME_BYTES));

    assign idle_inc = (idle_reg == '1) ? idle_reg : idle_reg + TICK_W'(1);

    // a zero timeout fires on the first tick, same as a timeout of one
    assign stat.link_lost = (s_data.op == OP_TICK) && link_reg && (idle_inc >= timeout_reg);
    assign stat.frame_ok  = (s_data.op == OP_BYTE) && (pos_eff == POS_W'(FRAME_BYTES - 1))
                            && ok0_reg && ok1_reg && (s_data.data_byte == sum_eff);

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ack_addr_reg     <= ACK_ADDR_RST;
            default_addr_reg <= DEFAULT_ADDR_RST;
            timeout_reg      <= TIMEOUT_RST;
            throttle_pos_reg <= THROTTLE_POS_RST;
            yaw_pos_reg      <= YAW_POS_RST;
            pitch_pos_reg    <= PITCH_POS_RST;
            roll_pos_reg     <= ROLL_POS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ACK_ADDR:     ack_addr_reg     <= cfg_data;
                CFG_DEFAULT_ADDR: default_addr_reg <= cfg_data;
                CFG_TIMEOUT:      timeout_reg      <= cfg_data[TICK_W-1:0];
                CFG_THROTTLE_POS: throttle_pos_reg <= cfg_data[3:0];
                CFG_YAW_POS:      yaw_pos_reg      <= cfg_data[3:0];
                CFG_PITCH_POS:    pitch_pos_reg    <= cfg_data[3:0];
                CFG_ROLL_POS:     roll_pos_reg     <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // frame tracking and link state
    always_comb begin
        pos_next      = pos_reg;
        sum_next      = sum_reg;
        link_next     = link_reg;
        idle_next     = idle_reg;
        cur_addr_next = cur_addr_reg;
        if (byte_wr) begin
            pos_next = pos_eff + POS_W'(1);
            if (pos_eff < POS_W'(FRAME_BYTES - 1)) begin
                sum_next = sum_eff + s_data.data_byte;
            end
            if (stat.frame_ok) begin
                idle_next = '0;
                link_next = 1'b1;
            end
        end else if (is_byte) begin
            // surplus byte: only a frame start would have reset the position
            pos_next = pos_eff;
            sum_next = sum_eff;
        end
        if (is_tick) begin
            idle_next = idle_inc;
            if (stat.link_lost) begin
                link_next     = 1'b0;
                cur_addr_next = default_addr_reg;
            end
        end
        if (cmd.load_ack && cmd.ack_last) begin
            cur_addr_next = ack_addr_reg;
        end
        if (cfg_valid && (cfg_index == CFG_DEFAULT_ADDR) && !link_reg) begin
            cur_addr_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            sum_reg      <= '0;
            link_reg     <= 1'b0;
            idle_reg     <= '0;
            cur_addr_reg <= DEFAULT_ADDR_RST;
        end else begin
            pos_reg      <= pos_next;
            sum_reg      <= sum_next;
            link_reg     <= link_next;
            idle_reg     <= idle_next;
            cur_addr_reg <= cur_addr_next;
        end
    end

    // header checks at write time
    always_ff @(posedge aclk) begin
        if (byte_wr && pos_eff == POS_W'(0)) begin
            ok0_reg <= (s_data.data_byte == HDR_BYTE0);
        end
        if (byte_wr && pos_eff == POS_W'(1)) begin
            ok1_reg <= (s_data.data_byte == HDR_BYTE1);
        end
    end

    // frame store, one write and one registered read port
    always_comb begin
        rd_addr = cmd.idx;
        if (cmd.rd_stick) begin
            case (cmd.idx)
                IDX_W'(0): rd_addr = roll_pos_reg;
                IDX_W'(1): rd_addr = pitch_pos_reg;
                IDX_W'(2): rd_addr = yaw_pos_reg;
                IDX_W'(3): rd_addr = throttle_pos_reg;
                default:   rd_addr = BUTTON_POS;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (byte_wr) begin
            frame_mem[pos_eff[IDX_W-1:0]] <= s_data.data_byte;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.cap_en) begin
            stick_reg[cmd.cap_idx] <= rd_data_reg;
        end
    end

    // ack byte selection
    assign addr_byte  = 3'(cmd.idx - IDX_W'(4));
    assign addr_shift = ack_addr_reg >> {addr_byte, 3'b000};

    always_comb begin
        case (cmd.idx) inside
            IDX_W'(0):                     ack_val = HDR_BYTE0;
            IDX_W'(1):                     ack_val = ACK_BYTE1;
            IDX_W'(3):                     ack_val = ACK_BYTE3;
            [IDX_W'(4):IDX_W'(8)]:         ack_val = addr_shift[7:0];
            LAST_IDX:                      ack_val = ack_sum_reg;
            default:                       ack_val = rd_data_reg;   // sequence and echoed bytes
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_update) begin
            ack_sum_reg <= '0;
        end else if (cmd.load_ack) begin
            ack_sum_reg <= ack_sum_reg + ack_val;
        end
    end

    // result register
    always_comb begin
        out_next = out_reg;
        if (cmd.accept && stat.link_lost) begin
            out_next               = '0;
            out_next.kind          = KIND_LOST;
            out_next.last          = 1'b1;
            out_next.radio_address = default_addr_reg;
            out_next.connected     = 1'b0;
        end else if (cmd.load_update) begin
            out_next               = '0;
            out_next.kind          = KIND_UPDATE;
            out_next.roll          = stick_reg[0];
            out_next.pitch         = stick_reg[1];
            out_next.yaw           = stick_reg[2];
            out_next.throttle      = stick_reg[3];
            out_next.buttons       = stick_reg[4];
            out_next.last          = 1'b0;
            out_next.radio_address = cur_addr_reg;
            out_next.connected     = 1'b1;
        end else if (cmd.load_ack) begin
            out_next               = '0;
            out_next.kind          = KIND_ACK;
            out_next.ack_byte      = ack_val;
            out_next.last          = cmd.ack_last;
            out_next.radio_address = cur_addr_reg;
            out_next.connected     = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_data = out_reg;

endmodule

/* rtl/rc_frame_link_keeper.sv */
// ----------------------------------------------------------------------------
// rc_frame_link_keeper
// Radio control frame receiver with ack generation and link-loss timer.
// ----------------------------------------------------------------------------
// Frame bytes and millisecond ticks are each taken while the block is idle
// and the result register is free. The last byte of a valid frame starts a
// sequence of 17 results (one control update, then 16 ack bytes); input is
// held off during it. The update reads the frame store, which has one write
// and one registered read port, for the four stick positions and the button
// byte, and each ack byte needs a read and a load. A tick that hits the
// timeout loads its link-lost result in the same cycle. Configuration writes
// are taken every cycle.
// ----------------------------------------------------------------------------
module rc_frame_link_keeper (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rcflk_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rcflk_pkg::ADDR_W-1:0]      cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rcflk_pkg::rcflk_in_t              s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rcflk_pkg::rcflk_out_t             m_data
);
    import rcflk_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    rcflk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rcflk_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data)
    );

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for rc_frame_link_keeper. A queue of frame bytes and
// ticks feeds a valid/ready driver; a clocked monitor runs an in-bench model
// of the frame check, ack builder and link timer on every accepted input and
// compares each accepted result field by field. Traffic runs in phases, with
// register settings changed while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    import rcflk_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;   // no register behind it
    localparam int DRAIN_CYCLES = 64;

    typedef enum int {FLAW_NONE, FLAW_HDR0, FLAW_HDR1, FLAW_SUM, FLAW_SHORT} flaw_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [ADDR_W-1:0]      cfg_data;
    logic                   s_valid;
    logic                   s_ready;
    rcflk_in_t              s_data;
    logic                   m_valid;
    logic                   m_ready;
    rcflk_out_t             m_data;

    rc_frame_link_keeper dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // stimulus and scoreboard
    rcflk_in_t  radio_stream [$];
    rcflk_out_t due_results [$];
    int         mismatches = 0;
    int         src_idle_pct = 27;
    int         sink_idle_pct = 27;
    int         stall_left = 0;
    bit         send_hold = 0;
    logic       in_taken = 1'b0;

    // model state
    logic [ADDR_W-1:0] ack_addr_reg;
    logic [ADDR_W-1:0] dflt_addr_reg;
    logic [TICK_W-1:0] tmo_reg;
    logic [3:0]        thr_pos, yaw_pos, pit_pos, roll_pos;
    logic [7:0]        frame_bytes [FRAME_BYTES];
    logic [4:0]        rx_pos;
    logic [7:0]        rx_sum;
    logic              link_up;
    logic [TICK_W-1:0] idle_cnt;
    logic [ADDR_W-1:0] cur_addr;

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                   input logic [ADDR_W-1:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic advance_link(input rcflk_in_t it);
        rcflk_out_t r;
        logic [7:0] ack [FRAME_BYTES];
        logic [7:0] sum;
        if (it.op == OP_TICK) begin
            if (idle_cnt != '1)
                idle_cnt++;
            if (link_up && idle_cnt >= tmo_reg) begin
                link_up = 1'b0;
                cur_addr = dflt_addr_reg;
                r = '0;
                r.kind = KIND_LOST;
                r.last = 1'b1;
                r.radio_address = cur_addr;
                due_results.push_back(r);
            end
            return;
        end
        if (it.frame_start) begin
            rx_pos = '0;
            rx_sum = '0;
        end
        if (rx_pos >= FRAME_BYTES)
            return;
        frame_bytes[rx_pos[3:0]] = it.data_byte;
        if (rx_pos < FRAME_BYTES - 1)
            rx_sum += it.data_byte;
        rx_pos++;
        if (rx_pos < FRAME_BYTES)
            return;
        if (frame_bytes[0] != HDR_BYTE0 || frame_bytes[1] != HDR_BYTE1 ||
            frame_bytes[FRAME_BYTES-1] != rx_sum)
            return;

        idle_cnt = '0;
        link_up = 1'b1;
        r = '0;
        r.kind = KIND_UPDATE;
        r.roll = frame_bytes[roll_pos];
        r.pitch = frame_bytes[pit_pos];
        r.yaw = frame_bytes[yaw_pos];
        r.throttle = frame_bytes[thr_pos];
        r.buttons = frame_bytes[BUTTON_POS];
        r.radio_address = cur_addr;
        r.connected = 1'b1;
        due_results.push_back(r);

        ack[0] = HDR_BYTE0;
        ack[1] = ACK_BYTE1;
        ack[2] = frame_bytes[2];
        ack[3] = ACK_BYTE3;
        for (int i = 0; i < 5; i++)
            ack[4+i] = ack_addr_reg[8*i +: 8];
        for (int i = 9; i < FRAME_BYTES - 1; i++)
            ack[i] = frame_bytes[i];
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            sum += ack[i];
        ack[FRAME_BYTES-1] = sum;
        for (int i = 0; i < FRAME_BYTES; i++) begin
            r = '0;
            r.kind = KIND_ACK;
            r.ack_byte = ack[i];
            r.last = (i == FRAME_BYTES - 1);
            r.radio_address = cur_addr;
            r.connected = 1'b1;
            due_results.push_back(r);
        end
        cur_addr = ack_addr_reg;
    endtask

    task automatic check_result(input rcflk_out_t got);
        rcflk_out_t want;
        if (due_results.size() == 0) begin
            report_mismatch("result with nothing expected, kind", ADDR_W'(got.kind), '0);
            return;
        end
        want = due_results.pop_front();
        if (got.kind !== want.kind)
            report_mismatch("kind", ADDR_W'(got.kind), ADDR_W'(want.kind));
        if (got.roll !== want.roll)
            report_mismatch("roll", ADDR_W'(got.roll), ADDR_W'(want.roll));
        if (got.pitch !== want.pitch)
            report_mismatch("pitch", ADDR_W'(got.pitch), ADDR_W'(want.pitch));
        if (got.yaw !== want.yaw)
            report_mismatch("yaw", ADDR_W'(got.yaw), ADDR_W'(want.yaw));
        if (got.throttle !== want.throttle)
            report_mismatch("throttle", ADDR_W'(got.throttle), ADDR_W'(want.throttle));
        if (got.buttons !== want.buttons)
            report_mismatch("buttons", ADDR_W'(got.buttons), ADDR_W'(want.buttons));
        if (got.ack_byte !== want.ack_byte)
            report_mismatch("ack_byte", ADDR_W'(got.ack_byte), ADDR_W'(want.ack_byte));
        if (got.last !== want.last)
            report_mismatch("last", ADDR_W'(got.last), ADDR_W'(want.last));
        if (got.radio_address !== want.radio_address)
            report_mismatch("radio_address", got.radio_address, want.radio_address);
        if (got.connected !== want.connected)
            report_mismatch("connected", ADDR_W'(got.connected), ADDR_W'(want.connected));
    endtask

    // monitor: model the accepted input first, then check any result taken at this edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                advance_link(s_data);
            if (m_valid && m_ready)
                check_result(m_data);
        end
        in_taken <= aresetn && s_valid && s_ready;
    end

    // input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (radio_stream.size() != 0 && !send_hold &&
                $urandom_range(0, 99) >= src_idle_pct) begin
                s_data  <= radio_stream.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result receiver; stall_left forces a long hold-off
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    function automatic logic [ADDR_W-1:0] rand40();
        return {8'($urandom()), 32'($urandom())};
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ACK_ADDR:     ack_addr_reg = val;
            CFG_DEFAULT_ADDR: begin
                dflt_addr_reg = val;
                if (!link_up)
                    cur_addr = val;
            end
            CFG_TIMEOUT:      tmo_reg = val[TICK_W-1:0];
            CFG_THROTTLE_POS: thr_pos = val[3:0];
            CFG_YAW_POS:      yaw_pos = val[3:0];
            CFG_PITCH_POS:    pit_pos = val[3:0];
            CFG_ROLL_POS:     roll_pos = val[3:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // upper bits of the narrow registers carry junk that must be dropped
    task automatic program_regs(input logic [ADDR_W-1:0] ack, input logic [ADDR_W-1:0] dflt,
                                input logic [TICK_W-1:0] tmo, input logic [3:0] thr,
                                input logic [3:0] yaw, input logic [3:0] pit,
                                input logic [3:0] roll);
        logic [ADDR_W-1:0] junk = rand40();
        write_reg(CFG_ACK_ADDR, ack);
        write_reg(CFG_DEFAULT_ADDR, dflt);
        write_reg(CFG_TIMEOUT, {junk[ADDR_W-1:TICK_W], tmo});
        write_reg(CFG_THROTTLE_POS, {junk[ADDR_W-1:4], thr});
        write_reg(CFG_YAW_POS, {~junk[ADDR_W-1:4], yaw});
        write_reg(CFG_PITCH_POS, {junk[ADDR_W-1:4], pit});
        write_reg(CFG_ROLL_POS, {~junk[ADDR_W-1:4], roll});
        write_reg(CFG_UNUSED, rand40());
    endtask

    task automatic push_byte(input logic [7:0] d, input logic st);
        rcflk_in_t it;
        it.op = OP_BYTE;
        it.data_byte = d;
        it.frame_start = st;
        radio_stream.push_back(it);
    endtask

    task automatic push_tick();
        rcflk_in_t it;
        it.op = OP_TICK;
        it.data_byte = 8'($urandom());
        it.frame_start = 1'($urandom());
        radio_stream.push_back(it);
    endtask

    task automatic push_frame(input flaw_t flaw, input int tick_pct, input int start_pct);
        logic [7:0] b [FRAME_BYTES];
        logic [7:0] sum;
        int cut;
        b[0] = HDR_BYTE0;
        b[1] = HDR_BYTE1;
        sum = '0;
        for (int i = 2; i < FRAME_BYTES - 1; i++)
            b[i] = 8'($urandom());
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            sum += b[i];
        b[FRAME_BYTES-1] = sum;
        case (flaw)
            FLAW_HDR0: b[0] ^= 8'($urandom_range(1, 255));
            FLAW_HDR1: b[1] ^= 8'($urandom_range(1, 255));
            FLAW_SUM:  b[FRAME_BYTES-1] ^= 8'($urandom_range(1, 255));
            default: ;
        endcase
        cut = (flaw == FLAW_SHORT) ? $urandom_range(1, FRAME_BYTES - 1) : FRAME_BYTES;
        for (int i = 0; i < cut; i++) begin
            if ($urandom_range(0, 99) < tick_pct)
                push_tick();
            push_byte(b[i], i == 0 && $urandom_range(0, 99) < start_pct);
        end
    endtask

    // mostly clean frames with random content, the rest ticks and damaged traffic
    task automatic queue_traffic(input int n);
        int added = 0;
        int r, k;
        while (added < n) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                push_frame(FLAW_NONE, 10, 92);
                added += FRAME_BYTES;
            end else if (r < 72) begin
                k = $urandom_range(1, 6);
                repeat (k) push_tick();
                added += k;
            end else if (r < 87) begin
                push_frame(flaw_t'($urandom_range(FLAW_HDR0, FLAW_SHORT)), 10, 92);
                added += FRAME_BYTES;
            end else if (r < 93) begin
                // bytes past a complete frame are dropped
                repeat ($urandom_range(1, 3)) push_byte(8'($urandom()), 1'b0);
            end else begin
                k = $urandom_range(1, 4);
                repeat (k) push_byte(8'($urandom()), 1'($urandom()));
                added += k;
            end
        end
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (radio_stream.size() != 0 || s_valid || due_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] b [FRAME_BYTES];
        logic [7:0] sum;

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        m_ready   = 1'b0;

        ack_addr_reg  = ACK_ADDR_RST;
        dflt_addr_reg = DEFAULT_ADDR_RST;
        tmo_reg       = TIMEOUT_RST;
        thr_pos       = THROTTLE_POS_RST;
        yaw_pos       = YAW_POS_RST;
        pit_pos       = PITCH_POS_RST;
        roll_pos      = ROLL_POS_RST;
        rx_pos        = '0;
        rx_sum        = '0;
        link_up       = 1'b0;
        idle_cnt      = '0;
        cur_addr      = DEFAULT_ADDR_RST;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: frame right after reset with no start marker, stick extremes,
        // surplus bytes, a tick with random ignored bits, then a partial frame
        b[0] = HDR_BYTE0;
        b[1] = HDR_BYTE1;
        b[2] = 8'hFF;
        b[3] = 8'h00;
        b[4] = 8'hFF;
        b[5] = 8'h00;
        b[6] = 8'h80;
        b[7] = 8'h7F;
        b[8] = 8'hA5;
        for (int i = 9; i < FRAME_BYTES - 1; i++)
            b[i] = (i % 2) ? 8'hFF : 8'h5A;
        sum = '0;
        for (int i = 0; i < FRAME_BYTES - 1; i++)
            sum += b[i];
        b[FRAME_BYTES-1] = sum;
        for (int i = 0; i < FRAME_BYTES; i++)
            push_byte(b[i], 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        push_tick();
        push_byte(HDR_BYTE0, 1'b1);
        push_byte(HDR_BYTE1, 1'b0);
        push_byte(8'hFF, 1'b0);
        wait_idle();

        program_regs(rand40(), rand40(), 16'd4, 4'($urandom()), 4'($urandom()),
                     4'($urandom()), 4'($urandom()));
        queue_traffic(45);
        wait_idle();

        // zero timeout, extreme positions; receiver stalls while frames pile up
        program_regs('1, '0, 16'd0, 4'd0, 4'd15, 4'd1, 4'd15);
        queue_traffic(45);
        @(posedge aclk);
        stall_left = 400;
        wait_idle();

        // sender pauses mid-phase until the block has drained
        program_regs('0, '1, 16'd1, 4'd15, 4'd0, 4'd8, 4'd3);
        queue_traffic(45);
        while (radio_stream.size() > 30)
            @(posedge aclk);
        send_hold = 1'b1;
        do @(posedge aclk); while (s_valid || due_results.size() != 0);
        send_hold = 1'b0;
        wait_idle();

        // longest timeout: a run of ticks far short of it, no idling on either side
        src_idle_pct = 0;
        sink_idle_pct = 0;
        program_regs(rand40(), rand40(), '1, 4'($urandom()), 4'($urandom()),
                     4'($urandom()), 4'($urandom()));
        push_frame(FLAW_NONE, 0, 100);
        repeat (24) push_tick();
        wait_idle();
        src_idle_pct = 27;
        sink_idle_pct = 27;

        repeat (3) begin
            program_regs(rand40(), rand40(), 16'($urandom_range(2, 12)), 4'($urandom()),
                         4'($urandom()), 4'($urandom()), 4'($urandom()));
            queue_traffic(45);
            wait_idle();
        end

        src_idle_pct = 0;
        sink_idle_pct = 0;
        program_regs(rand40(), rand40(), 16'($urandom_range(1, 8)), 4'($urandom()),
                     4'($urandom()), 4'($urandom()), 4'($urandom()));
        queue_traffic(45);
        wait_idle();

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
